// ===== hdl/tcce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine: shared package
// Command codes, character codes, register indexes and the result types that
// pass between the engine and the output stage.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int COL_W  = 7;   // cursor column, place_col
  localparam int ROW_W  = 5;   // rows, place_row, start and blank rows
  localparam int ADDR_W = 11;  // physical cell index
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CMD_W  = 2;
  localparam int WORD_W = ATTR_W + CHAR_W;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FORCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PLACE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  localparam logic REG_ATTRIBUTE     = 1'b0;
  localparam logic REG_CURSOR_ENABLE = 1'b1;

  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_address;
    logic [WORD_W-1:0] cell_word;
    logic              row_blank;
    logic [ROW_W-1:0]  blank_row_index;
    logic              cursor_update;
    logic [ADDR_W-1:0] cursor_address;
    logic [ROW_W-1:0]  start_row;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    clear;  // item is a clear: the output stage runs the blanking burst
    result_t res;
  } item_t;

endpackage

// ===== hdl/tcce_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine: command engine
// Holds the cursor and the rotating top row, and works out the result of one
// command combinationally.
// ----------------------------------------------------------------------------
module tcce_engine import tcce_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CMD_W-1:0]  command,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [COL_W-1:0]  place_col,
  input  logic [ROW_W-1:0]  place_row,
  input  logic [ATTR_W-1:0] attribute,
  input  logic              cursor_enable,
  output item_t             item
);

  localparam logic [COL_W:0]   COL_LIMIT = (COL_W+1)'(COLUMNS);
  localparam logic [COL_W:0]   COL_LAST  = (COL_W+1)'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [ROW_W:0]   ROW_COUNT = (ROW_W+1)'(ROWS);

  logic [COL_W-1:0] cursor_col, cursor_col_next;
  logic [ROW_W-1:0] cursor_row, cursor_row_next;
  logic [ROW_W-1:0] top_row, top_row_next;

  logic [COL_W:0]   col_wide;
  logic             printable;
  logic             store;
  logic             newline;
  logic             scrolled;
  logic [ROW_W-1:0] freed;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] new_addr;

  // Next tab stop for every column, built at elaboration.
  logic [COL_W:0] tab_lut [2**COL_W];

  for (genvar g = 0; g < 2**COL_W; g++) begin : g_tab
    assign tab_lut[g] = (COL_W+1)'((g / TAB_WIDTH + 1) * TAB_WIDTH);
  end

  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= ROW_COUNT) begin
      sum = sum - ROW_COUNT;
    end
    return ADDR_W'(int'(sum[ROW_W-1:0]) * COLUMNS + int'(col));
  endfunction

  assign printable = (char_code[7] == 1'b0) && (char_code[6:5] != 2'b00);

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    top_row_next    = top_row;
    col_wide        = {1'b0, cursor_col};
    store           = 1'b0;
    newline         = 1'b0;
    scrolled        = 1'b0;
    freed           = '0;
    case (command)
      CMD_CLEAR: begin
        cursor_col_next = '0;
        cursor_row_next = '0;
        top_row_next    = '0;
      end
      CMD_PLACE: begin
        cursor_col_next = ({1'b0, place_col} > COL_LAST) ? COL_LAST[COL_W-1:0] : place_col;
        cursor_row_next = (place_row > ROW_LAST) ? ROW_LAST : place_row;
      end
      default: begin
        if (command == CMD_FORCE || printable) begin
          store    = 1'b1;
          col_wide = {1'b0, cursor_col} + 1'b1;
        end else begin
          case (char_code)
            CH_BS: begin
              if (cursor_col != '0) begin
                col_wide = {1'b0, cursor_col} - 1'b1;
              end
            end
            CH_TAB: col_wide = tab_lut[cursor_col];
            CH_CR:  col_wide = '0;
            CH_LF: begin
              col_wide = '0;
              newline  = 1'b1;
            end
            default: col_wide = {1'b0, cursor_col};
          endcase
        end
        // Running past the last column wraps onto the next line.
        if (col_wide >= COL_LIMIT) begin
          col_wide = '0;
          newline  = 1'b1;
        end
        cursor_col_next = col_wide[COL_W-1:0];
        if (newline) begin
          if (cursor_row == ROW_LAST) begin
            scrolled     = 1'b1;
            freed        = top_row;
            top_row_next = (top_row == ROW_LAST) ? '0 : top_row + 1'b1;
          end else begin
            cursor_row_next = cursor_row + 1'b1;
          end
        end
      end
    endcase
  end

  assign cur_addr = phys_addr(top_row, cursor_row, cursor_col);
  assign new_addr = phys_addr(top_row_next, cursor_row_next, cursor_col_next);

  always_comb begin
    item.clear               = (command == CMD_CLEAR);
    item.res.cell_write      = store;
    item.res.cell_address    = store ? cur_addr : '0;
    item.res.cell_word       = store ? {attribute, char_code} : '0;
    item.res.row_blank       = scrolled;
    item.res.blank_row_index = freed;
    item.res.cursor_update   = cursor_enable;
    item.res.cursor_address  = new_addr;
    item.res.start_row       = top_row_next;
    item.res.last            = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      top_row    <= '0;
    end else if (step) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      top_row    <= top_row_next;
    end
  end

endmodule

// ===== hdl/tcce_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine: output stage
// Result register, plus the row counter that turns a clear into one blanking
// result per row.
// ----------------------------------------------------------------------------
module tcce_out_stage import tcce_pkg::*; #(
  parameter int ROWS = 25
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  item_t   item,
  input  logic    cursor_enable,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  logic             out_free;
  logic             burst;
  logic             burst_step;
  logic             burst_end;
  logic [ROW_W-1:0] row_cnt;
  result_t          blank_res;

  assign out_free   = !out_valid || out_ready;
  assign can_load   = out_free && !burst;
  assign burst_step = burst && out_free;
  assign burst_end  = (row_cnt == ROW_LAST);

  // A clear leaves the cursor and the start row at zero, so only the row
  // index, the last flag and the cursor update change along the burst.
  always_comb begin
    blank_res                 = '0;
    blank_res.row_blank       = 1'b1;
    blank_res.blank_row_index = burst ? row_cnt : '0;
    blank_res.last            = burst && burst_end;
    blank_res.cursor_update   = burst && burst_end && cursor_enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      burst     <= 1'b0;
      row_cnt   <= '0;
    end else begin
      if (load || burst_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load && item.clear) begin
        burst   <= 1'b1;
        row_cnt <= ROW_W'(1);
      end else if (burst_step) begin
        if (burst_end) begin
          burst <= 1'b0;
        end else begin
          row_cnt <= row_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= item.clear ? blank_res : item.res;
    end else if (burst_step) begin
      res <= blank_res;
    end
  end

endmodule

// ===== hdl/text_console_cursor_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character writer for a ROWS x COLUMNS text screen with a rotating start row.
// ----------------------------------------------------------------------------
// Commands arrive one per transfer on the input channel: write a character
// (printable bytes are stored, backspace, tab, carriage return and line feed
// move the cursor, other bytes are ignored), force-write any byte, place the
// cursor (clamped to the screen) or clear. Scrolling never copies memory: the
// start row advances and the freed physical row is reported for blanking in
// the same result as any character store. Write and place commands give one
// result each and are taken at one per cycle while the output stage can load;
// the combinational cursor update between the input register and the result
// register sets this rate. A clear gives ROWS results (one per physical row,
// in order) and holds the input side while the output stage's row counter
// steps through them. The configuration channel is always ready; attribute and
// cursor_enable should be written only while no command is in flight.
module text_console_cursor_engine_core import tcce_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [ATTR_W-1:0] cfg_data,
  // command channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [COL_W-1:0]  place_col,
  input  logic [ROW_W-1:0]  place_row,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              cell_write,
  output logic [ADDR_W-1:0] cell_address,
  output logic [WORD_W-1:0] cell_word,
  output logic              row_blank,
  output logic [ROW_W-1:0]  blank_row_index,
  output logic              cursor_update,
  output logic [ADDR_W-1:0] cursor_address,
  output logic [ROW_W-1:0]  start_row,
  output logic              last
);

  // Configuration registers.
  logic [ATTR_W-1:0] attribute;
  logic              cursor_enable;

  // Input register: holds one command until the engine can commit it.
  logic              ireg_valid;
  logic [CMD_W-1:0]  ireg_command;
  logic [CHAR_W-1:0] ireg_char_code;
  logic [COL_W-1:0]  ireg_place_col;
  logic [ROW_W-1:0]  ireg_place_row;

  logic    advance;
  logic    can_load;
  item_t   item;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute     <= 8'd15;
      cursor_enable <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ATTRIBUTE:     attribute     <= cfg_data;
        REG_CURSOR_ENABLE: cursor_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The engine commits a command whenever the output stage can take its
  // result, so a new transfer is accepted in the same cycle.
  assign advance  = ireg_valid && can_load;
  assign in_ready = !ireg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg_command   <= command;
      ireg_char_code <= char_code;
      ireg_place_col <= place_col;
      ireg_place_row <= place_row;
    end
  end

  tcce_engine #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .command       (ireg_command),
    .char_code     (ireg_char_code),
    .place_col     (ireg_place_col),
    .place_row     (ireg_place_row),
    .attribute     (attribute),
    .cursor_enable (cursor_enable),
    .item          (item)
  );

  tcce_out_stage #(
    .ROWS (ROWS)
  ) u_out_stage (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .item          (item),
    .cursor_enable (cursor_enable),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .res           (res)
  );

  assign cell_write      = res.cell_write;
  assign cell_address    = res.cell_address;
  assign cell_word       = res.cell_word;
  assign row_blank       = res.row_blank;
  assign blank_row_index = res.blank_row_index;
  assign cursor_update   = res.cursor_update;
  assign cursor_address  = res.cursor_address;
  assign start_row       = res.start_row;
  assign last            = res.last;

endmodule
